>>> sv/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("hbp check failed: next-cycle property");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("hbp check failed: same-cycle property");

`endif

>>> sv/hbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman bit packer package
// Shared constants, operation codes and types of the code bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int MAX_CODE_LENGTH = 16;
  localparam int SYMBOL_COUNT    = 257;
  localparam int END_SYMBOL      = 256;

  localparam int OP_W     = 2;
  localparam int SYM_W    = 9;
  localparam int CODE_W   = 16;
  localparam int LEN_IN_W = 5;
  localparam int BYTE_W   = 8;
  localparam int FREE_W   = $clog2(BYTE_W + 1);
  localparam int ADDR_W   = $clog2(SYMBOL_COUNT);
  localparam int LEN_W    = $clog2(MAX_CODE_LENGTH + 1);
  localparam int CNT_W    = (LEN_W > FREE_W) ? LEN_W : FREE_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] val;
  } code_entry_t;

  typedef struct packed {
    logic              start;
    logic              finish;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] val;
  } pack_req_t;

  typedef struct packed {
    logic idle;
  } pack_stat_t;

endpackage

>>> sv/hbp_code_table.sv
// ----------------------------------------------------------------------------
// Code table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hbp_code_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [hbp_pkg::ADDR_W-1:0]  wr_addr,
  input  hbp_pkg::code_entry_t        wr_data,
  input  logic                        rd_en,
  input  logic [hbp_pkg::ADDR_W-1:0]  rd_addr,
  output hbp_pkg::code_entry_t        rd_data
);

  hbp_pkg::code_entry_t mem [hbp_pkg::SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/hbp_packer.sv
// ----------------------------------------------------------------------------
// Bit packer
// Packs one code MSB first into the held byte, one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module hbp_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  hbp_pkg::pack_req_t          req,
  output hbp_pkg::pack_stat_t         stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last_byte
);

  localparam int LEN_W  = hbp_pkg::LEN_W;
  localparam int CODE_W = hbp_pkg::CODE_W;
  localparam int BYTE_W = hbp_pkg::BYTE_W;
  localparam int FREE_W = hbp_pkg::FREE_W;
  localparam int CNT_W  = hbp_pkg::CNT_W;

  typedef enum logic [1:0] {
    P_IDLE,
    P_RUN,
    P_LAST
  } pstate_t;

  pstate_t             state;
  logic [BYTE_W-1:0]   held;
  logic [FREE_W-1:0]   free;
  logic [LEN_W-1:0]    len;
  logic [CODE_W-1:0]   val;
  logic                fin;

  logic [CODE_W-1:0]   val_masked;
  logic [CNT_W-1:0]    len_c;
  logic [CNT_W-1:0]    free_c;
  logic [CNT_W-1:0]    spill_shift;
  logic [CNT_W-1:0]    merge_shift;
  logic                spill;
  logic                slot_free;
  logic                load_out;
  logic [BYTE_W-1:0]   spill_bits;
  logic [BYTE_W-1:0]   merge_bits;

  always_comb begin
    val_masked  = val & ~({CODE_W{1'b1}} << len);
    len_c       = CNT_W'(len);
    free_c      = CNT_W'(free);
    spill       = len_c > free_c;
    spill_shift = len_c - free_c;
    merge_shift = free_c - len_c;
    spill_bits  = BYTE_W'(val_masked >> spill_shift);
    merge_bits  = BYTE_W'(val_masked << merge_shift);
    slot_free   = !out_valid || !out_stall;
    load_out    = slot_free && (((state == P_RUN) && spill) || (state == P_LAST));
  end

  assign stat.idle = (state == P_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= P_IDLE;
      held      <= '0;
      free      <= FREE_W'(BYTE_W);
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        P_IDLE: begin
          if (req.start) begin
            len   <= req.len;
            val   <= req.val;
            fin   <= req.finish;
            state <= P_RUN;
          end
        end
        P_RUN: begin
          if (spill) begin
            if (slot_free) begin
              out_byte  <= held | spill_bits;
              last_byte <= 1'b0;
              held      <= '0;
              free      <= FREE_W'(BYTE_W);
              len       <= LEN_W'(spill_shift);
            end
          end else begin
            held  <= held | merge_bits;
            free  <= FREE_W'(merge_shift);
            state <= fin ? P_LAST : P_IDLE;
          end
        end
        P_LAST: begin
          if (slot_free) begin
            out_byte  <= held;
            last_byte <= 1'b1;
            held      <= '0;
            free      <= FREE_W'(BYTE_W);
            state     <= P_IDLE;
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Code table plus MSB-first packer of Huffman codes into bytes.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one item per handshake:
// a table load, a data byte to encode, or a stream finish. The output
// channel (out_valid, out_stall) carries packed bytes, earliest bit in
// bit 7, with last_byte set on the zero-padded final byte of a stream.
// A load writes the code table directly. An encode reads the code
// table, then sends each output byte filled by the code, then merges the
// rest into the held byte. A finish does the same and then sends the
// final byte. The packer sends at most one byte per cycle through its
// output register; while the receiver stalls and the packer has a byte
// to send, the packer waits and in_stall stays high. The first result
// byte of an item passes the table read register, the packer state and
// the output register before it appears.
// Reset empties the held byte and the output register. The code table is
// not cleared: every entry must be loaded before it is used.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hbp_pkg::OP_W-1:0]      operation,
  input  logic [hbp_pkg::SYM_W-1:0]     symbol,
  input  logic [hbp_pkg::CODE_W-1:0]    code_bits,
  input  logic [hbp_pkg::LEN_IN_W-1:0]  code_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hbp_pkg::BYTE_W-1:0]    out_byte,
  output logic                          last_byte
);

  typedef enum logic {
    T_IDLE,
    T_LOOK
  } tstate_t;

  tstate_t                     state;
  logic                        fin;
  logic                        hit;

  logic                        accept;
  logic                        is_load;
  logic                        is_encode;
  logic                        is_finish;
  logic [hbp_pkg::SYM_W-1:0]   look_sym;
  logic                        look_in_range;
  logic                        load_in_range;
  logic [hbp_pkg::LEN_W-1:0]   len_clamped;

  logic                        wr_en;
  logic                        rd_en;
  logic [hbp_pkg::ADDR_W-1:0]  rd_addr;
  hbp_pkg::code_entry_t        wr_data;
  hbp_pkg::code_entry_t        rd_data;
  hbp_pkg::pack_req_t          pk_req;
  hbp_pkg::pack_stat_t         pk_stat;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_finish = 1'b0;
    unique case (hbp_pkg::op_t'(operation))
      hbp_pkg::OP_LOAD:   is_load   = 1'b1;
      hbp_pkg::OP_ENCODE: is_encode = 1'b1;
      hbp_pkg::OP_FINISH: is_finish = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    in_stall      = (state == T_LOOK) || !pk_stat.idle;
    accept        = in_valid && !in_stall;
    look_sym      = is_finish ? hbp_pkg::SYM_W'(hbp_pkg::END_SYMBOL) : symbol;
    look_in_range = int'(look_sym) < hbp_pkg::SYMBOL_COUNT;
    load_in_range = int'(symbol) < hbp_pkg::SYMBOL_COUNT;
    len_clamped   = (int'(code_length) > hbp_pkg::MAX_CODE_LENGTH) ?
                    hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_LENGTH) :
                    hbp_pkg::LEN_W'(code_length);
    wr_en         = accept && is_load && load_in_range;
    wr_data.len   = len_clamped;
    wr_data.val   = code_bits;
    rd_en         = accept && (is_encode || is_finish);
    rd_addr       = look_in_range ? hbp_pkg::ADDR_W'(look_sym) : '0;
  end

  always_comb begin
    pk_req.start  = (state == T_LOOK);
    pk_req.finish = fin;
    pk_req.len    = hit ? rd_data.len : '0;
    pk_req.val    = rd_data.val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      fin   <= 1'b0;
      hit   <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (rd_en) begin
            fin   <= is_finish;
            hit   <= look_in_range;
            state <= T_LOOK;
          end
        end
        T_LOOK: begin
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  hbp_code_table u_code_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (hbp_pkg::ADDR_W'(symbol)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hbp_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .req       (pk_req),
    .stat      (pk_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

>>> sv/hbp_checker.sv
// ----------------------------------------------------------------------------
// Huffman bit packer checker
// Port-level properties of the code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [hbp_pkg::OP_W-1:0]      operation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hbp_pkg::BYTE_W-1:0]    out_byte,
  input logic                          last_byte
);

  logic in_acc;
  logic load_acc;
  logic look_acc;

  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (operation == hbp_pkg::OP_LOAD);
  assign look_acc = in_acc && ((operation == hbp_pkg::OP_ENCODE) ||
                               (operation == hbp_pkg::OP_FINISH));

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_byte) && $stable(last_byte))
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)
  `ASSERT_NEXT(a_load_ready, clk, rst, load_acc, !in_stall)
  `ASSERT_NEXT(a_lookup_busy, clk, rst, look_acc, in_stall)

endmodule

bind huffman_code_bit_packer hbp_checker u_hbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .operation (operation),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .last_byte (last_byte)
);

>>> tb/tb_huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Loads code table entries, encodes data bytes and finishes streams through
// the valid/stall input channel, and checks every packed byte against a
// bit-accurate packer prediction kept alongside the block. Both channels
// idle in random bursts except in calm phases and near the end of the run.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer;
  import hbp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 350;
  localparam int CALM_TAIL    = 60;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_IN_W-1:0] code_length;
  } packer_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_byte_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation   = OP_LOAD;
  logic [SYM_W-1:0]    symbol      = '0;
  logic [CODE_W-1:0]   code_bits   = '0;
  logic [LEN_IN_W-1:0] code_length = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_byte;

  huffman_code_bit_packer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_byte   (last_byte)
  );

  packer_item_t item_queue[$];
  packed_byte_t byte_queue[$];
  packer_item_t driven_item;
  int           sent_count     = 0;
  int           accepted_count = 0;
  int           error_count    = 0;
  int           cycle_count    = 0;
  int           in_gap         = 0;
  int           out_gap        = 0;
  bit           calm           = 1'b0;
  bit           idle_ok;
  logic         next_valid;

  // Generator bookkeeping: which table entries hold a code.
  bit table_loaded[SYMBOL_COUNT];
  int loaded_symbols[$];

  // Predicted packer state.
  logic [CODE_W-1:0] code_value_table[SYMBOL_COUNT];
  int                code_length_table[SYMBOL_COUNT];
  logic [BYTE_W-1:0] held_bits = '0;
  int                free_bits = BYTE_W;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic add_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                          input logic [CODE_W-1:0] bits, input logic [LEN_IN_W-1:0] len);
    packer_item_t it;
    it = '{operation: op, symbol: sym, code_bits: bits, code_length: len};
    item_queue.push_back(it);
    if (op == OP_LOAD && sym < SYMBOL_COUNT && !table_loaded[sym]) begin
      table_loaded[sym] = 1'b1;
      loaded_symbols.push_back(int'(sym));
    end
  endtask

  task automatic pack_code(input int sym);
    int unsigned len;
    int unsigned val;
    int unsigned room;
    int unsigned part;
    len = 0;
    val = 0;
    if (sym < SYMBOL_COUNT) begin
      len = code_length_table[sym];
      val = 32'(code_value_table[sym]);
    end
    if (len == 0) return;
    val = val & ((32'd1 << len) - 1);
    room = free_bits;
    while (len > room) begin
      part = val >> (len - room);
      byte_queue.push_back('{value: held_bits | part[BYTE_W-1:0], last: 1'b0});
      len = len - room;
      val = val & ((32'd1 << len) - 1);
      room = BYTE_W;
      held_bits = '0;
    end
    part = val << (room - len);
    held_bits = held_bits | part[BYTE_W-1:0];
    free_bits = room - len;
  endtask

  task automatic predict_item(input packer_item_t it);
    int len;
    len = int'(it.code_length);
    if (len > MAX_CODE_LENGTH) len = MAX_CODE_LENGTH;
    if (it.operation == OP_LOAD) begin
      if (it.symbol < SYMBOL_COUNT) begin
        code_value_table[it.symbol] = it.code_bits;
        code_length_table[it.symbol] = len;
      end
    end else if (it.operation == OP_ENCODE) begin
      pack_code(int'(it.symbol));
    end else if (it.operation == OP_FINISH) begin
      pack_code(END_SYMBOL);
      byte_queue.push_back('{value: held_bits, last: 1'b1});
      held_bits = '0;
      free_bits = BYTE_W;
    end
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      idle_ok = !calm && item_queue.size() > CALM_TAIL;
      if (!(in_valid && accepted_count != sent_count)) begin
        next_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (idle_ok && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 8);
        end else if (item_queue.size() > 0) begin
          driven_item = item_queue.pop_front();
          operation   <= driven_item.operation;
          symbol      <= driven_item.symbol;
          code_bits   <= driven_item.code_bits;
          code_length <= driven_item.code_length;
          next_valid  = 1'b1;
          sent_count++;
        end
        in_valid <= next_valid;
      end
      if (out_gap > 0) begin
        out_gap--;
      end else if (idle_ok && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    packed_byte_t want;
    cycle_count++;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_item(driven_item);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (byte_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
        end else begin
          want = byte_queue.pop_front();
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.value));
          if (last_byte !== want.last)
            report_mismatch($sformatf("last_byte %0b, expected %0b", last_byte, want.last));
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_huffman_code_bit_packer: FAIL");
      $finish;
    end
  end

  initial begin
    int count;
    int pick;
    logic [SYM_W-1:0] sym;
    logic [LEN_IN_W-1:0] len;

    // Directed part: empty finish, clamped and zero lengths, stray code bits,
    // ignored loads, out-of-range encodes and the unused operation.
    add_item(OP_LOAD, 9'd256, 16'hFFFF, 5'd0);
    add_item(OP_FINISH, 9'd0, 16'h0000, 5'd0);
    add_item(OP_LOAD, 9'd0, 16'h0000, 5'd0);
    add_item(OP_LOAD, 9'd255, 16'hFFFF, 5'd16);
    add_item(OP_LOAD, 9'd1, 16'hFFFF, 5'd3);
    add_item(OP_LOAD, 9'd2, 16'h0001, 5'd1);
    add_item(OP_LOAD, 9'd3, 16'hAAAA, 5'd31);
    add_item(OP_LOAD, 9'd257, 16'h1234, 5'd7);
    add_item(OP_LOAD, 9'd511, 16'hFFFF, 5'd31);
    add_item(OP_ENCODE, 9'd0, 16'hFFFF, 5'd31);
    add_item(OP_ENCODE, 9'd255, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd2, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd3, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd1, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd300, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd511, 16'h0000, 5'd0);
    add_item(OP_UNUSED, 9'd511, 16'hFFFF, 5'd31);
    add_item(OP_LOAD, 9'd256, 16'hFFF5, 5'd3);
    add_item(OP_ENCODE, 9'd255, 16'h0000, 5'd0);
    add_item(OP_FINISH, 9'd0, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd2, 16'h0000, 5'd0);
    add_item(OP_ENCODE, 9'd255, 16'h0000, 5'd0);
    add_item(OP_FINISH, 9'd511, 16'hFFFF, 5'd31);

    count = 0;
    while (count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        sym = ($urandom_range(0, 9) == 0) ? SYM_W'($urandom_range(257, 511)) :
                                            SYM_W'($urandom_range(0, 256));
        len = ($urandom_range(0, 9) == 0) ? LEN_IN_W'($urandom_range(17, 31)) :
                                            LEN_IN_W'($urandom_range(0, 16));
        add_item(OP_LOAD, sym, CODE_W'($urandom), len);
        count++;
      end else if (pick < 16) begin
        add_item(OP_UNUSED, SYM_W'($urandom), CODE_W'($urandom), LEN_IN_W'($urandom));
      end else if (pick < 26) begin
        add_item(OP_FINISH, SYM_W'($urandom), CODE_W'($urandom), LEN_IN_W'($urandom));
        count++;
      end else begin
        if ($urandom_range(0, 9) == 0)
          sym = SYM_W'($urandom_range(257, 511));
        else
          sym = SYM_W'(loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)]);
        add_item(OP_ENCODE, sym, CODE_W'($urandom), LEN_IN_W'($urandom));
        count++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (item_queue.size() == 0 && accepted_count == sent_count);
    wait (byte_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_huffman_code_bit_packer: PASS");
    else
      $display("tb_huffman_code_bit_packer: FAIL");
    $finish;
  end

endmodule
